// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the regulator RTL.
// Included by the files that carry concurrent checks; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property sampled on the rising clock edge, off while reset is asserted.
`define ELPI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ELPI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ELPI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/elpi_pkg.sv =====
// Shared types and constants of the electronic load PI regulator.
// Used by the core and the testbench; depends on nothing.
package elpi_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_W      = 20;
    localparam int DAC_W      = 16;
    localparam int ERR_W      = 32;
    localparam int INTEG_W    = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_P_DIV    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_I_DIV    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DAC_ZERO = 3'd5;

    localparam logic [DIV_W-1:0] P_DIV_RST    = 20'd50;
    localparam logic [DIV_W-1:0] I_DIV_RST    = 20'd100;
    localparam logic [DAC_W-1:0] DAC_ZERO_RST = 16'd4095;

    localparam int INTEG_LIMIT = 100000;
    localparam int RES_SCALE   = 1000;
    localparam int RES_SAT     = 65535000;

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = 18'sd100000;
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = -18'sd100000;

    localparam logic OP_REGULATE = 1'b0;
    localparam logic OP_CLEAR    = 1'b1;

    typedef enum logic [1:0] {
        MODE_CV,
        MODE_CR,
        MODE_CP,
        MODE_NONE
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_RDIV_GO,
        ST_RDIV_WAIT,
        ST_ERR,
        ST_PI_GO,
        ST_PI_WAIT,
        ST_INTEG,
        ST_SUM,
        ST_CODE
    } state_t;

endpackage

// ===== rtl/core/elpi_sdiv.sv =====
// Bit-serial restoring divider for unsigned operands, one quotient bit per cycle.
// Standalone; takes its checks from assert_macros.svh.
`include "assert_macros.svh"

module elpi_sdiv #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 20
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] den_reg, den_next;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fits;

    // The dividend shifts out of the top of q_reg while quotient bits enter at the bottom.
    assign trial = {rem_reg, q_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W - 1);
            rem_next  = '0;
            q_next    = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            q_next   = {q_reg[NUM_W-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

    `ELPI_ASSERT_IMP(a_start_idle, clk, rst_n, start, !busy_reg, "divider restarted while busy")
    `ELPI_ASSERT_IMP(a_done_idle, clk, rst_n, done_reg, !busy_reg, "divider done while busy")
    `ELPI_ASSERT_NXT(a_last_step, clk, rst_n, busy_reg && (cnt_reg == '0) && !start, done_reg,
        "divider missed its done pulse")

endmodule

// ===== rtl/core/electronic_load_pi_regulator_core.sv =====
// Top level of the electronic load PI regulator: configuration, sequencer and datapath.
// Depends on elpi_pkg, elpi_sdiv and assert_macros.svh.
//
//  channel   direction  handshake                 payload
//  s_*       in         s_tvalid / s_tready       s_tdata = samples, s_tuser = opcode
//  m_*       out        m_tvalid / m_tready       m_tdata = DAC code
//  cfg_*     in         cfg_we (no wait)          cfg_index, cfg_wdata
//
// One item is worked on at a time. In constant voltage mode the time for an item
// is set by the two 32-step error dividers running side by side. Constant
// power adds the MUL_W-step shift-add multiplier (MUL_W = max(SAMPLE_WIDTH, 10)),
// constant resistance adds that multiplier plus the (SAMPLE_WIDTH + MUL_W)-step
// resistance divider. A clear or an item giving no result stays in the idle state.
// Reset is asynchronous and active low; it loads the register defaults and zeroes
// the integral. A finished code waits in the output register while the next item
// is accepted; the sequencer only holds in its last state if that register is
// still occupied when the next code is ready.
`include "assert_macros.svh"

module electronic_load_pi_regulator_core
    import elpi_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // s_tdata fields from bit 0 up: voltage_mv, current_ma, zero padding.
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]      s_tdata,
    // s_tuser fields from bit 0 up: opcode.
    input  logic                                     s_tuser,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // m_tdata fields from bit 0 up: dac_code.
    output logic [DAC_W-1:0]                         m_tdata,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    input  logic                                     cfg_we,
    input  logic [CFG_IDX_W-1:0]                     cfg_index,
    input  logic [CFG_DATA_W-1:0]                    cfg_wdata
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int MUL_W  = (SW > 10) ? SW : 10;
    localparam int PW     = SW + MUL_W;
    localparam int EW     = ((PW > ERR_W) ? PW : ERR_W) + 2;
    localparam int MCNT_W = $clog2(MUL_W);
    localparam int SUM_W  = ERR_W + 2;
    localparam int CODE_W = SUM_W + 1;

    localparam logic signed [EW-1:0]    ERR_MAX_E = EW'(64'sd2147483647);
    localparam logic signed [EW-1:0]    ERR_MIN_E = EW'(-64'sd2147483648);
    localparam logic signed [SUM_W-1:0] LIM_HI    = SUM_W'(INTEG_LIMIT);
    localparam logic signed [SUM_W-1:0] LIM_LO    = SUM_W'(-INTEG_LIMIT);

    // Configuration registers.
    logic              enable_reg;
    mode_t             mode_reg;
    logic [31:0]       setpoint_reg;
    logic [DIV_W-1:0]  p_div_reg;
    logic [DIV_W-1:0]  i_div_reg;
    logic [DAC_W-1:0]  zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            mode_reg     <= MODE_CV;
            setpoint_reg <= '0;
            p_div_reg    <= P_DIV_RST;
            i_div_reg    <= I_DIV_RST;
            zero_reg     <= DAC_ZERO_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENABLE:   enable_reg   <= cfg_wdata[0];
                CFG_MODE:     mode_reg     <= mode_t'(cfg_wdata[1:0]);
                CFG_SETPOINT: setpoint_reg <= cfg_wdata[31:0];
                CFG_P_DIV:    p_div_reg    <= cfg_wdata[DIV_W-1:0];
                CFG_I_DIV:    i_div_reg    <= cfg_wdata[DIV_W-1:0];
                CFG_DAC_ZERO: zero_reg     <= cfg_wdata[DAC_W-1:0];
                default:      ;
            endcase
        end
    end

    // Sequencer and datapath registers.
    state_t                    state_reg, state_next;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic [MCNT_W-1:0]         mcnt_reg, mcnt_next;
    logic                      out_valid_reg, out_valid_next;
    logic [DAC_W-1:0]          out_data_reg, out_data_next;
    logic [SW-1:0]             v_reg, v_next;
    logic [SW-1:0]             i_reg, i_next;
    logic [PW-1:0]             mc_reg, mc_next;
    logic [MUL_W-1:0]          mp_reg, mp_next;
    logic [PW-1:0]             acc_reg, acc_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;

    logic             accept;
    logic             res_start;
    logic             pi_start;
    logic             r_done, p_done, i_done;
    logic [PW-1:0]    rq;
    logic [ERR_W-1:0] pq, iq;
    logic [ERR_W-1:0] err_mag;
    logic [DIV_W-1:0] p_den, i_den;

    logic signed [EW-1:0]     opnd, sp_ext, err_full;
    logic signed [SUM_W-1:0]  integ_ext, iq_ext, pq_ext, integ_full;
    logic signed [CODE_W-1:0] zero_ext, code_full;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // The error dividers work on the magnitude of the error; the sign is applied afterwards,
    // which gives the truncation toward zero. A zero divisor register acts as one.
    assign err_mag = err_reg[ERR_W-1] ? (~err_reg + 1'b1) : err_reg;
    assign p_den   = (p_div_reg == '0) ? DIV_W'(1) : p_div_reg;
    assign i_den   = (i_div_reg == '0) ? DIV_W'(1) : i_div_reg;

    // v * 1000 / i for constant resistance; i is known to be nonzero on this path.
    elpi_sdiv #(
        .NUM_W (PW),
        .DEN_W (SW)
    ) u_rdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (res_start),
        .num   (acc_reg),
        .den   (i_reg),
        .done  (r_done),
        .quot  (rq)
    );

    elpi_sdiv #(
        .NUM_W (ERR_W),
        .DEN_W (DIV_W)
    ) u_pdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pi_start),
        .num   (err_mag),
        .den   (p_den),
        .done  (p_done),
        .quot  (pq)
    );

    elpi_sdiv #(
        .NUM_W (ERR_W),
        .DEN_W (DIV_W)
    ) u_idiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pi_start),
        .num   (err_mag),
        .den   (i_den),
        .done  (i_done),
        .quot  (iq)
    );

    // Error operand: the mode picks voltage, resistance or power, all zero-extended.
    always_comb
    begin
        sp_ext = $signed(EW'(setpoint_reg));
        case (mode_reg)
            MODE_CR: opnd = (i_reg == '0) ? $signed(EW'(RES_SAT)) : $signed(EW'(rq));
            MODE_CP: opnd = $signed(EW'(acc_reg));
            default: opnd = $signed(EW'(v_reg));
        endcase
        err_full = (mode_reg == MODE_CP) ? (sp_ext - opnd) : (opnd - sp_ext);
    end

    always_comb
    begin
        integ_ext  = SUM_W'(integ_reg);
        iq_ext     = $signed(SUM_W'(iq));
        pq_ext     = $signed(SUM_W'(pq));
        integ_full = err_reg[ERR_W-1] ? (integ_ext - iq_ext) : (integ_ext + iq_ext);
        zero_ext   = $signed(CODE_W'(zero_reg));
        code_full  = zero_ext - CODE_W'(sum_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        integ_next     = integ_reg;
        mcnt_next      = mcnt_reg;
        v_next         = v_reg;
        i_next         = i_reg;
        mc_next        = mc_reg;
        mp_next        = mp_reg;
        acc_next       = acc_reg;
        err_next       = err_reg;
        sum_next       = sum_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        res_start      = 1'b0;
        pi_start       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    v_next = s_tdata[SW-1:0];
                    i_next = s_tdata[2*SW-1:SW];
                    if (s_tuser == OP_CLEAR)
                    begin
                        integ_next = '0;
                    end
                    else if (enable_reg && (mode_reg != MODE_NONE))
                    begin
                        if (mode_reg == MODE_CV)
                        begin
                            state_next = ST_ERR;
                        end
                        else
                        begin
                            // Shift-add multiply: v * 1000 for resistance, v * i for power.
                            state_next = ST_MUL;
                            mc_next    = PW'(s_tdata[SW-1:0]);
                            mp_next    = (mode_reg == MODE_CR) ? MUL_W'(RES_SCALE)
                                                               : MUL_W'(s_tdata[2*SW-1:SW]);
                            acc_next   = '0;
                            mcnt_next  = MCNT_W'(MUL_W - 1);
                        end
                    end
                end
            end
            ST_MUL:
            begin
                if (mp_reg[0])
                begin
                    acc_next = acc_reg + mc_reg;
                end
                mc_next = {mc_reg[PW-2:0], 1'b0};
                mp_next = {1'b0, mp_reg[MUL_W-1:1]};
                if (mcnt_reg == '0)
                begin
                    // With zero current the resistance saturates and no division runs.
                    if ((mode_reg == MODE_CR) && (i_reg != '0))
                    begin
                        state_next = ST_RDIV_GO;
                    end
                    else
                    begin
                        state_next = ST_ERR;
                    end
                end
                else
                begin
                    mcnt_next = mcnt_reg - 1'b1;
                end
            end
            ST_RDIV_GO:
            begin
                res_start  = 1'b1;
                state_next = ST_RDIV_WAIT;
            end
            ST_RDIV_WAIT:
            begin
                if (r_done)
                begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                if (err_full > ERR_MAX_E)
                begin
                    err_next = ERR_MAX_E[ERR_W-1:0];
                end
                else if (err_full < ERR_MIN_E)
                begin
                    err_next = ERR_MIN_E[ERR_W-1:0];
                end
                else
                begin
                    err_next = err_full[ERR_W-1:0];
                end
                state_next = ST_PI_GO;
            end
            ST_PI_GO:
            begin
                pi_start   = 1'b1;
                state_next = ST_PI_WAIT;
            end
            ST_PI_WAIT:
            begin
                if (p_done && i_done)
                begin
                    state_next = ST_INTEG;
                end
            end
            ST_INTEG:
            begin
                if (integ_full > LIM_HI)
                begin
                    integ_next = INTEG_MAX;
                end
                else if (integ_full < LIM_LO)
                begin
                    integ_next = INTEG_MIN;
                end
                else
                begin
                    integ_next = integ_full[INTEG_W-1:0];
                end
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                sum_next   = err_reg[ERR_W-1] ? (SUM_W'(integ_reg) - pq_ext)
                                              : (SUM_W'(integ_reg) + pq_ext);
                state_next = ST_CODE;
            end
            ST_CODE:
            begin
                // Hold here until the output register is free.
                if (!out_valid_reg || m_tready)
                begin
                    if (code_full[CODE_W-1])
                    begin
                        out_data_next = '0;
                    end
                    else if (code_full > zero_ext)
                    begin
                        out_data_next = zero_reg;
                    end
                    else
                    begin
                        out_data_next = code_full[DAC_W-1:0];
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            integ_reg     <= '0;
            mcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            integ_reg     <= integ_next;
            mcnt_reg      <= mcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg        <= v_next;
        i_reg        <= i_next;
        mc_reg       <= mc_next;
        mp_reg       <= mp_next;
        acc_reg      <= acc_next;
        err_reg      <= err_next;
        sum_reg      <= sum_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `ELPI_ASSERT(a_integ_bound, clk, rst_n, (integ_reg <= INTEG_MAX) && (integ_reg >= INTEG_MIN),
        "integral outside its clamp")
    `ELPI_ASSERT_IMP(a_code_bound, clk, rst_n, m_tvalid, m_tdata <= zero_reg,
        "DAC code above the zero code")
    `ELPI_ASSERT_NXT(a_clear, clk, rst_n, accept && (s_tuser == OP_CLEAR), integ_reg == '0,
        "clear transaction left the integral nonzero")
    `ELPI_ASSERT_NXT(a_disabled, clk, rst_n, accept && !enable_reg, state_reg == ST_IDLE,
        "disabled regulator started work")

endmodule

// ===== tb/dac_code_checker.sv =====
// Scoreboard for the electronic load PI regulator: follows register writes, predicts DAC codes.
// Depends on elpi_pkg; instantiated by tb_top beside the regulator core.
`timescale 1ns / 100ps

module dac_code_checker
    import elpi_pkg::*;
#(
    parameter int SW      = SAMPLE_WIDTH_DEF,
    parameter int TDATA_W = ((2*SW+7)/8)*8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [TDATA_W-1:0]    s_tdata,
    input  logic                  s_tuser,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [DAC_W-1:0]      m_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatch_count,
    output int                    codes_pending
);

    localparam longint ERR_HI = 64'sd2147483647;
    localparam longint ERR_LO = -64'sd2147483648;

    logic                       enable_q;
    mode_t                      mode_q;
    logic [31:0]                setpoint_q;
    logic [DIV_W-1:0]           p_div_q;
    logic [DIV_W-1:0]           i_div_q;
    logic [DAC_W-1:0]           zero_q;
    logic signed [INTEG_W-1:0]  integral_q;
    logic [DAC_W-1:0]           expected_codes[$];

    // Works out the DAC code for one sample and advances the integral, or zeroes it on a clear.
    // Returns 1 when the sample yields a code.
    function automatic bit regulate(input logic op, input logic [SW-1:0] v_mv,
                                    input logic [SW-1:0] i_ma,
                                    output logic [DAC_W-1:0] code);
        longint v;
        longint i;
        longint sp;
        longint err;
        longint pd;
        longint id;
        longint prop;
        longint acc;
        longint raw;
        v    = longint'(v_mv);
        i    = longint'(i_ma);
        sp   = longint'(setpoint_q);
        code = '0;
        if (op == OP_CLEAR) begin
            integral_q = '0;
            return 1'b0;
        end
        if (!enable_q) return 1'b0;
        case (mode_q)
            MODE_CV: err = v - sp;
            MODE_CR: err = ((i == 0) ? longint'(RES_SAT) : (v * RES_SCALE) / i) - sp;
            MODE_CP: err = sp - v * i;
            default: return 1'b0;
        endcase
        if (err > ERR_HI) err = ERR_HI;
        if (err < ERR_LO) err = ERR_LO;
        // A divisor register holding zero divides by one.
        pd   = (p_div_q == '0) ? 64'sd1 : longint'(p_div_q);
        id   = (i_div_q == '0) ? 64'sd1 : longint'(i_div_q);
        prop = err / pd;
        acc  = longint'(integral_q) + err / id;
        if (acc > INTEG_LIMIT) acc = INTEG_LIMIT;
        if (acc < -INTEG_LIMIT) acc = -INTEG_LIMIT;
        integral_q = INTEG_W'(acc);
        raw = longint'(zero_q) - (prop + acc);
        if (raw < 0) raw = 0;
        if (raw > longint'(zero_q)) raw = longint'(zero_q);
        code = DAC_W'(raw);
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        logic [DAC_W-1:0] predicted;
        logic [DAC_W-1:0] want;
        if (!rst_n) begin
            enable_q   = 1'b0;
            mode_q     = MODE_CV;
            setpoint_q = '0;
            p_div_q    = P_DIV_RST;
            i_div_q    = I_DIV_RST;
            zero_q     = DAC_ZERO_RST;
            integral_q = '0;
            expected_codes.delete();
            mismatch_count <= 0;
            codes_pending  <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_codes.size() == 0) begin
                    $display("%0t: dac_code %0d arrived, expected no transaction",
                             $time, m_tdata);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = expected_codes.pop_front();
                    if (m_tdata !== want) begin
                        $display("%0t: dac_code mismatch: expected %0d, got %0d",
                                 $time, want, m_tdata);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (regulate(s_tuser, s_tdata[SW-1:0], s_tdata[2*SW-1:SW], predicted))
                    expected_codes.push_back(predicted);
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ENABLE:   enable_q   = cfg_wdata[0];
                    CFG_MODE:     mode_q     = mode_t'(cfg_wdata[1:0]);
                    CFG_SETPOINT: setpoint_q = cfg_wdata;
                    CFG_P_DIV:    p_div_q    = cfg_wdata[DIV_W-1:0];
                    CFG_I_DIV:    i_div_q    = cfg_wdata[DIV_W-1:0];
                    CFG_DAC_ZERO: zero_q     = cfg_wdata[DAC_W-1:0];
                    default:      ;
                endcase
            end
            codes_pending <= expected_codes.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the regulator testbench: clock, reset, stimulus, output back-pressure and verdict.
// Depends on elpi_pkg, electronic_load_pi_regulator_core and dac_code_checker.
`timescale 1ns / 100ps

module tb_top;
    import elpi_pkg::*;

    localparam int SW             = SAMPLE_WIDTH_DEF;
    localparam int TDATA_W        = ((2*SW+7)/8)*8;
    localparam int ITEM_TARGET    = 1400;
    // Past this many counted samples the run drops all idling on both sides.
    localparam int QUIET_AFTER    = 1250;
    // Pause that outlasts the slowest sample (constant resistance).
    localparam int SETTLE_CYCLES  = 120;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PRESSURE_PHASE = 3;

    // Register indexes the block does not decode; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic [TDATA_W-1:0]    s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DAC_W-1:0]      m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int mismatch_count;
    int codes_pending;

    // Idling control shared by the sample driver and the DAC-side receiver.
    bit quiet          = 1'b0;
    bit no_gaps        = 1'b0;
    int long_hold_req  = 0;
    int long_hold_done = 0;
    int rx_hold        = 0;

    int stuck_cycles   = 0;
    int items_counted  = 0;
    int phase_no       = 0;

    always #5 clk = ~clk;

    electronic_load_pi_regulator_core #(
        .SAMPLE_WIDTH(SW)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    dac_code_checker #(
        .SW(SW)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tdata       (m_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .mismatch_count(mismatch_count),
        .codes_pending (codes_pending)
    );

    // DAC-side receiver. It drops tready in bursts of random length, and once
    // per request from the stimulus it holds tready low for a stretch set by LONG_HOLD so that the
    // output register stays full and the core has to stall its sample input.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else if (long_hold_done != long_hold_req) begin
            long_hold_done <= long_hold_req;
            rx_hold        <= LONG_HOLD - 1;
            m_tready       <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (!no_gaps && $urandom_range(0, 9) == 0) begin
            rx_hold  <= $urandom_range(0, 13);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: counts cycles in which neither channel completes a transaction.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("electronic_load_pi_regulator_core test failed");
            $finish;
        end
    end

    // One register write. The enable is lowered in the cycle after it is raised, so back-to-back
    // writes never assign cfg_we twice in the same time step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Writes every register. With junk set, the unused upper bits carry random
    // values, which the core must discard.
    task automatic configure(input logic en, input mode_t md, input logic [31:0] sp,
                             input logic [DIV_W-1:0] pd, input logic [DIV_W-1:0] id,
                             input logic [DAC_W-1:0] zc, input bit junk);
        logic [31:0] hi;
        hi = junk ? $urandom : 32'd0;
        write_reg(CFG_ENABLE,   {hi[31:1], en});
        write_reg(CFG_MODE,     {hi[31:2], md});
        write_reg(CFG_SETPOINT, sp);
        write_reg(CFG_P_DIV,    {hi[31:DIV_W], pd});
        write_reg(CFG_I_DIV,    {hi[31:DIV_W], id});
        write_reg(CFG_DAC_ZERO, {hi[31:DAC_W], zc});
    endtask

    // Offers one sample transaction and returns at the edge that accepts it.
    // tvalid stays high afterwards, so a following sample continues without a bubble.
    task automatic send_sample(input logic op, input logic [SW-1:0] v_mv,
                               input logic [SW-1:0] i_ma);
        if (!no_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= TDATA_W'({i_ma, v_mv});
        do @(posedge clk); while (!s_tready);
    endtask

    // Brings the core to rest: all codes collected, then a pause that covers a
    // sample still in flight that yields no code (a clear, or a disabled regulate).
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (codes_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SW-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return SW'(1);
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic logic [DIV_W-1:0] pick_divisor(input int lo, input int hi);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DIV_W'(1);
            2:       return '1;
            default: return DIV_W'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic logic [DAC_W-1:0] pick_zero_code();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return DAC_ZERO_RST;
            default: return DAC_W'($urandom);
        endcase
    endfunction

    // One random phase: new register settings at rest, then a run of samples with
    // the occasional integral clear. Setpoints and divisors are scaled to the mode
    // so that most codes land inside the output range instead of at a bound.
    task automatic random_phase();
        logic           en;
        mode_t          md;
        logic [31:0]    sp;
        logic [DIV_W-1:0] pd;
        logic [DIV_W-1:0] id;
        int             n;
        logic           op;
        logic [SW-1:0]  v_mv;
        settle();
        if (items_counted >= QUIET_AFTER) quiet = 1'b1;
        no_gaps = quiet || ($urandom_range(0, 4) == 0);
        en = ($urandom_range(0, 7) != 0);
        md = ($urandom_range(0, 9) == 0) ? MODE_NONE : mode_t'($urandom_range(0, 2));
        if (phase_no == PRESSURE_PHASE) begin
            en = 1'b1;
            if (md == MODE_NONE) md = MODE_CV;
        end
        case (md)
            MODE_CV: begin
                sp = $urandom_range(0, 65535);
                pd = pick_divisor(1, 500);
                id = pick_divisor(1, 2000);
            end
            MODE_CR: begin
                sp = $urandom_range(0, 5000);
                pd = pick_divisor(1, 200);
                id = pick_divisor(1, 1000);
            end
            default: begin
                sp = $urandom;
                pd = pick_divisor(10000, 1048575);
                id = pick_divisor(20000, 1048575);
            end
        endcase
        if ($urandom_range(0, 7) == 0) sp = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
        if ($urandom_range(0, 5) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7, $urandom);
        configure(en, md, sp, pd, id, pick_zero_code(), $urandom_range(0, 1));
        if (phase_no == PRESSURE_PHASE) begin
            // Keep offering samples while the receiver sits on the output.
            no_gaps = 1'b1;
            long_hold_req <= long_hold_req + 1;
        end
        n = (en && md != MODE_NONE) ? $urandom_range(20, 60) : 6;
        for (int k = 0; k < n; k++) begin
            op = ($urandom_range(0, 11) == 0) ? OP_CLEAR : OP_REGULATE;
            // In constant voltage mode half of the voltages sit near the setpoint.
            if (md == MODE_CV && $urandom_range(0, 1) == 1)
                v_mv = SW'(sp + $urandom_range(0, 255) - 128);
            else
                v_mv = pick_sample();
            send_sample(op, v_mv, pick_sample());
            if (op == OP_CLEAR || (en && md != MODE_NONE)) items_counted++;
        end
        phase_no++;
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Out of reset the core is disabled: a regulate sample and a clear give no code.
        send_sample(OP_REGULATE, '1, '1);
        send_sample(OP_CLEAR, '0, '0);
        settle();

        // Writes to undecoded indexes must not disturb the reset defaults.
        write_reg(CFG_SPARE_6, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_7, 32'h0000_0001);
        write_reg(CFG_ENABLE, 32'd1);
        send_sample(OP_REGULATE, '0, '0);
        send_sample(OP_REGULATE, '1, '1);
        send_sample(OP_REGULATE, 16'h5555, 16'hAAAA);
        send_sample(OP_REGULATE, 16'hAAAA, 16'h5555);
        send_sample(OP_CLEAR, '1, '1);
        settle();

        // Full-scale setpoint drives the error below the int32 range; zero divisors.
        configure(1'b1, MODE_CV, 32'hFFFF_FFFF, '0, '0, '1, 1'b0);
        send_sample(OP_REGULATE, '0, '0);
        send_sample(OP_REGULATE, '1, '0);
        settle();

        // Constant resistance with zero current saturates the resistance.
        configure(1'b1, MODE_CR, 32'd0, DIV_W'(1), DIV_W'(1), '0, 1'b0);
        send_sample(OP_REGULATE, '1, '0);
        settle();
        configure(1'b1, MODE_CR, 32'd65535000, '1, '1, '1, 1'b0);
        send_sample(OP_REGULATE, 16'd1000, '0);
        send_sample(OP_REGULATE, '1, 16'd1);
        send_sample(OP_REGULATE, '0, '1);
        send_sample(OP_REGULATE, 16'd1, '1);
        settle();

        // Constant power: large products saturate the error in both directions.
        configure(1'b1, MODE_CP, 32'd0, DIV_W'(50000), DIV_W'(100000), DAC_ZERO_RST, 1'b0);
        send_sample(OP_REGULATE, '1, '1);
        send_sample(OP_REGULATE, 16'd1000, 16'd1000);
        settle();
        write_reg(CFG_SETPOINT, 32'hFFFF_FFFF);
        send_sample(OP_REGULATE, '0, '0);
        send_sample(OP_CLEAR, '0, '0);
        settle();

        // No-regulation mode: regulate gives nothing, a clear still zeroes the integral.
        write_reg(CFG_MODE, 32'(MODE_NONE));
        send_sample(OP_REGULATE, 16'd100, 16'd100);
        send_sample(OP_CLEAR, '0, '0);
        settle();

        // Unit divisors push the integral into its positive clamp.
        configure(1'b1, MODE_CV, 32'd0, DIV_W'(1), DIV_W'(1), DAC_ZERO_RST, 1'b0);
        send_sample(OP_REGULATE, '1, '0);
        send_sample(OP_REGULATE, '1, '0);

        while (items_counted < ITEM_TARGET) random_phase();

        settle();
        if (mismatch_count == 0 && codes_pending == 0)
            $display("electronic_load_pi_regulator_core test passed");
        else
            $display("electronic_load_pi_regulator_core test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/elpi_pkg.sv
rtl/core/elpi_sdiv.sv
rtl/core/electronic_load_pi_regulator_core.sv
tb/dac_code_checker.sv
tb/tb_top.sv
